// ===== sv/ubss_pkg.sv =====
`default_nettype none

package ubss_pkg;

  // field widths fixed by the interface
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned CFG_W    = 7;

  // configuration register indexes
  localparam logic [0:0] REG_PREFIX_MODE = 1'd0;
  localparam logic [0:0] REG_MIN_LENGTH  = 1'd1;

  // marker and printable range
  localparam logic [7:0]  MARK_FIRST = 8'hFF;
  localparam logic [7:0]  MARK_SECOND = 8'hFE;
  localparam logic [15:0] UNIT_MARK  = 16'hFEFF;
  localparam logic [15:0] UNIT_NUL   = 16'h0000;
  localparam logic [15:0] PRINT_LO   = 16'd32;
  localparam logic [15:0] PRINT_HI   = 16'd126;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [OFFSET_W-1:0] string_offset;
    logic [CHAR_W-1:0]   character;
    logic                last_of_string;
  } out_word_t;

  // finished string handed from scanner to emitter
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    count;
  } desc_t;

endpackage

`default_nettype wire

// ===== sv/utf16_bom_string_scanner_core.sv =====
// Output path: a kept string is read out once the byte that closes it has queued its
//   descriptor; each character passes through a registered buffer read, then the output
//   register, and the next character is read only once the previous one has reached it.
// Throughput: one byte per cycle while fewer than two finished strings await output;
//   the two buffer banks set that limit.
// Reset: synchronous, active high; clears scan state, queue and output valid.
//   The character buffer is not cleared.
`default_nettype none

module utf16_bom_string_scanner_core #(
  parameter int unsigned MAX_STRING_LEN = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ubss_pkg::in_word_t         in_payload,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ubss_pkg::out_word_t             out_payload,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [ubss_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;

  logic                          prefix_mode;
  logic [ubss_pkg::CFG_W-1:0]    min_length;
  logic                          accept;
  logic                          push;
  ubss_pkg::desc_t               push_desc;
  ubss_pkg::desc_t               q_head;
  logic                          q_head_slot;
  logic                          q_tail_slot;
  logic                          q_nonempty;
  logic                          q_full;
  logic                          q_pop;
  logic                          ram_we;
  logic [IDX_W:0]                ram_waddr;
  logic [ubss_pkg::CHAR_W-1:0]   ram_wdata;
  logic [IDX_W:0]                ram_raddr;
  logic [ubss_pkg::CHAR_W-1:0]   ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode <= 1'b0;
      min_length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ubss_pkg::REG_PREFIX_MODE: prefix_mode <= cfg_data[0];
        ubss_pkg::REG_MIN_LENGTH:  min_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // the bank being filled must not hold a string still awaiting output
  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  ubss_front #(.MAX_STRING_LEN(MAX_STRING_LEN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_payload  (in_payload),
    .prefix_mode (prefix_mode),
    .min_length  (min_length),
    .wr_bank     (q_tail_slot),
    .push        (push),
    .push_desc   (push_desc),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  ubss_desc_q u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .head_slot (q_head_slot),
    .tail_slot (q_tail_slot),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  // two banks of characters, one per queue slot
  ubss_ram #(
    .WIDTH (ubss_pkg::CHAR_W),
    .DEPTH (2 ** (IDX_W + 1))
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ubss_back #(.MAX_STRING_LEN(MAX_STRING_LEN)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .q_slot      (q_head_slot),
    .q_pop       (q_pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// ===== sv/ubss_ram.sv =====
`default_nettype none

module ubss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ubss_front.sv =====
`default_nettype none

module ubss_front #(
  parameter int unsigned MAX_STRING_LEN = 64,
  localparam int unsigned IDX_W = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire ubss_pkg::in_word_t        in_payload,
  input  wire logic                      prefix_mode,
  input  wire logic [ubss_pkg::CFG_W-1:0] min_length,
  input  wire logic                      wr_bank,
  output logic                           push,
  output ubss_pkg::desc_t                push_desc,
  output logic                           ram_we,
  output logic [IDX_W:0]                 ram_waddr,
  output logic [ubss_pkg::CHAR_W-1:0]    ram_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_STRING_LEN + 1);

  typedef enum logic [1:0] {PH_SEARCH, PH_LOW, PH_HIGH} phase_t;

  phase_t                          phase, phase_next;
  logic [ubss_pkg::OFFSET_W-1:0]   position, position_next;
  logic [7:0]                      prev_byte, prev_byte_next;
  logic                            prev_valid, prev_valid_next;
  logic [7:0]                      pend_low, pend_low_next;
  logic                            clean, clean_next;
  logic                            ovf, ovf_next;
  logic [ubss_pkg::OFFSET_W-1:0]   start_off, start_off_next;
  logic [CNT_W-1:0]                cnt, cnt_next;

  logic [15:0]      unit;
  logic             mid_flush;
  logic             open_str;
  logic             do_flush;
  logic             keep;
  logic [CNT_W-1:0] flush_cnt;
  logic             flush_clean;
  logic             flush_ovf;
  logic [7:0]       b;

  assign b    = in_payload.data_byte;
  assign unit = {b, pend_low};

  // per-byte scan step
  always_comb begin
    phase_next      = phase;
    position_next   = position + 32'd1;
    prev_byte_next  = prev_byte;
    prev_valid_next = prev_valid;
    pend_low_next   = pend_low;
    clean_next      = clean;
    ovf_next        = ovf;
    start_off_next  = start_off;
    cnt_next        = cnt;
    mid_flush       = 1'b0;
    open_str        = 1'b0;
    ram_we          = 1'b0;

    unique case (phase)
      PH_LOW: begin
        pend_low_next = b;
        phase_next    = PH_HIGH;
      end
      PH_HIGH: begin
        if (unit == ubss_pkg::UNIT_NUL) begin
          mid_flush       = 1'b1;
          phase_next      = PH_SEARCH;
          prev_byte_next  = b;
          prev_valid_next = prefix_mode;
        end else if (unit == ubss_pkg::UNIT_MARK) begin
          mid_flush = 1'b1;
          open_str  = 1'b1;
        end else if (unit < ubss_pkg::PRINT_LO || unit > ubss_pkg::PRINT_HI) begin
          if (prefix_mode) begin
            mid_flush       = 1'b1;
            phase_next      = PH_SEARCH;
            prev_byte_next  = b;
            prev_valid_next = 1'b1;
          end else begin
            clean_next = 1'b0;
            phase_next = PH_LOW;
          end
        end else begin
          if (cnt < CNT_W'(MAX_STRING_LEN)) begin
            ram_we   = accept;
            cnt_next = CNT_W'(cnt + 1'b1);
          end else begin
            ovf_next = 1'b1;
          end
          phase_next = PH_LOW;
        end
      end
      default: begin
        if (prev_valid && prev_byte == ubss_pkg::MARK_FIRST &&
            b == ubss_pkg::MARK_SECOND) begin
          open_str = 1'b1;
        end else begin
          prev_byte_next  = b;
          prev_valid_next = 1'b1;
        end
      end
    endcase

    // string as it stands before a new one opens
    flush_cnt   = cnt_next;
    flush_clean = clean_next;
    flush_ovf   = ovf_next;

    if (open_str) begin
      start_off_next  = position - 32'd1;
      phase_next      = PH_LOW;
      cnt_next        = '0;
      clean_next      = 1'b1;
      ovf_next        = 1'b0;
      prev_valid_next = 1'b0;
    end

    // a string opened by this byte is still empty at end of data
    do_flush = mid_flush |
               (in_payload.end_of_data & (phase_next != PH_SEARCH) & ~open_str);

    // end of image: back to reset values
    if (in_payload.end_of_data) begin
      phase_next      = PH_SEARCH;
      position_next   = '0;
      prev_byte_next  = '0;
      prev_valid_next = 1'b0;
      pend_low_next   = '0;
      clean_next      = 1'b1;
      ovf_next        = 1'b0;
      start_off_next  = '0;
      cnt_next        = '0;
    end
  end

  // keep rule
  always_comb begin
    if (flush_cnt == '0 || flush_ovf) begin
      keep = 1'b0;
    end else if (prefix_mode) begin
      keep = ubss_pkg::LEN_W'(flush_cnt) >= min_length;
    end else begin
      keep = flush_clean;
    end
  end

  assign push             = accept & do_flush & keep;
  assign push_desc.offset = start_off;
  assign push_desc.count  = ubss_pkg::LEN_W'(flush_cnt);

  assign ram_waddr = {wr_bank, cnt[IDX_W-1:0]};
  assign ram_wdata = unit[ubss_pkg::CHAR_W-1:0];

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      position   <= '0;
      prev_byte  <= '0;
      prev_valid <= 1'b0;
      pend_low   <= '0;
      clean      <= 1'b1;
      ovf        <= 1'b0;
      start_off  <= '0;
      cnt        <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      position   <= position_next;
      prev_byte  <= prev_byte_next;
      prev_valid <= prev_valid_next;
      pend_low   <= pend_low_next;
      clean      <= clean_next;
      ovf        <= ovf_next;
      start_off  <= start_off_next;
      cnt        <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ubss_desc_q.sv =====
`default_nettype none

module ubss_desc_q (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ubss_pkg::desc_t push_desc,
  input  wire logic            pop,
  output ubss_pkg::desc_t      head,
  output logic                 head_slot,
  output logic                 tail_slot,
  output logic                 nonempty,
  output logic                 full
);

  localparam logic [1:0] Q_DEPTH = 2'd2;

  ubss_pkg::desc_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  assign head      = slots[rd_ptr];
  assign head_slot = rd_ptr;
  assign tail_slot = wr_ptr;
  assign nonempty  = (fill != '0);
  assign full      = (fill == Q_DEPTH);

endmodule

`default_nettype wire

// ===== sv/ubss_back.sv =====
`default_nettype none

module ubss_back #(
  parameter int unsigned MAX_STRING_LEN = 64,
  localparam int unsigned IDX_W = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_nonempty,
  input  wire ubss_pkg::desc_t            q_head,
  input  wire logic                       q_slot,
  output logic                            q_pop,
  output logic [IDX_W:0]                  ram_raddr,
  input  wire logic [ubss_pkg::CHAR_W-1:0] ram_rdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ubss_pkg::out_word_t             out_payload
);

  logic [IDX_W-1:0]              idx;
  logic                          rd_pending;
  logic [ubss_pkg::OFFSET_W-1:0] p_offset;
  logic                          p_last;
  logic                          issue;
  logic                          last_rd;

  // read one character when the output register is free on arrival
  assign issue   = q_nonempty & ~rd_pending & (~out_valid | out_ready);
  assign last_rd = (8'(idx) + 8'd1) == 8'(q_head.count);
  assign q_pop   = issue & last_rd;
  assign ram_raddr = {q_slot, idx};

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (issue) begin
        idx <= last_rd ? '0 : IDX_W'(idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_offset <= q_head.offset;
      p_last   <= last_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pending) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_payload.string_offset  <= p_offset;
      out_payload.character      <= ram_rdata;
      out_payload.last_of_string <= p_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ubss_checker.sv =====
`default_nettype none

module ubss_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire ubss_pkg::in_word_t         in_payload,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire ubss_pkg::out_word_t        out_payload,
  input wire logic                       cfg_we,
  input wire logic [0:0]                 cfg_index,
  input wire logic [ubss_pkg::CFG_W-1:0] cfg_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output word changed while stalled");

  // only printable characters leave the block
  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_payload.character >= 7'd32 && out_payload.character <= 7'd126)
    else $error("non-printable character emitted");

  // reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind utf16_bom_string_scanner_core ubss_checker u_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;

  localparam int MAX_LEN = 64;

  typedef enum logic [1:0] {HUNT, WANT_LOW, WANT_HIGH} scan_phase_t;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  ubss_pkg::in_word_t         in_payload = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  ubss_pkg::out_word_t        out_payload;
  logic                       cfg_we     = 1'b0;
  logic [0:0]                 cfg_index  = '0;
  logic [ubss_pkg::CFG_W-1:0] cfg_data   = '0;

  utf16_bom_string_scanner_core #(.MAX_STRING_LEN(MAX_LEN)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload(out_payload),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // scanner mirror: registers and scan state
  logic                       prefix_q;
  logic [ubss_pkg::LEN_W-1:0] min_len_q;
  logic [31:0]                byte_pos;
  scan_phase_t                scan_ph;
  logic [7:0]                 prev_byte;
  logic                       prev_ok;
  logic [7:0]                 low_byte;
  logic                       clean;
  logic                       overflow;
  logic [31:0]                str_offset;
  logic [6:0]                 char_buf [MAX_LEN];
  int                         char_cnt;

  ubss_pkg::out_word_t expected_chars[$];
  ubss_pkg::in_word_t  image_q[$];
  int                  err_count  = 0;
  bit                  idle_on    = 1'b0;
  int                  stall_left = 0;

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic clear_scan();
    byte_pos   = '0;
    scan_ph    = HUNT;
    prev_byte  = '0;
    prev_ok    = 1'b0;
    low_byte   = '0;
    clean      = 1'b1;
    overflow   = 1'b0;
    str_offset = '0;
    char_cnt   = 0;
    foreach (char_buf[i]) char_buf[i] = '0;
  endtask

  task automatic open_string(logic [31:0] off);
    str_offset = off;
    scan_ph    = WANT_LOW;
    char_cnt   = 0;
    clean      = 1'b1;
    overflow   = 1'b0;
    prev_ok    = 1'b0;
  endtask

  // queue the held string as words if the keep rule passes
  task automatic emit_string(output int n);
    bit                  keep;
    ubss_pkg::out_word_t w;
    n = 0;
    if (char_cnt == 0 || overflow) return;
    keep = prefix_q ? (char_cnt >= min_len_q) : clean;
    if (!keep) return;
    for (int k = 0; k < char_cnt; k++) begin
      w.string_offset  = str_offset;
      w.character      = char_buf[k];
      w.last_of_string = (k == char_cnt - 1);
      expected_chars   = {expected_chars, w};
    end
    n = char_cnt;
  endtask

  // advance the mirror by one accepted byte
  task automatic scan_byte(ubss_pkg::in_word_t w);
    logic [15:0] unit;
    logic [31:0] pos;
    int          n;
    n   = 0;
    pos = byte_pos;
    case (scan_ph)
      WANT_LOW: begin
        low_byte = w.data_byte;
        scan_ph  = WANT_HIGH;
      end
      WANT_HIGH: begin
        unit = {w.data_byte, low_byte};
        if (unit == ubss_pkg::UNIT_NUL) begin
          emit_string(n);
          scan_ph   = HUNT;
          prev_byte = w.data_byte;
          prev_ok   = prefix_q;
        end else if (unit == ubss_pkg::UNIT_MARK) begin
          emit_string(n);
          open_string(pos - 1);
        end else if (unit < ubss_pkg::PRINT_LO || unit > ubss_pkg::PRINT_HI) begin
          if (prefix_q) begin
            emit_string(n);
            scan_ph   = HUNT;
            prev_byte = w.data_byte;
            prev_ok   = 1'b1;
          end else begin
            clean   = 1'b0;
            scan_ph = WANT_LOW;
          end
        end else begin
          if (char_cnt < MAX_LEN) begin
            char_buf[char_cnt] = unit[6:0];
            char_cnt++;
          end else begin
            overflow = 1'b1;
          end
          scan_ph = WANT_LOW;
        end
      end
      default: begin
        if (prev_ok && prev_byte == ubss_pkg::MARK_FIRST &&
            w.data_byte == ubss_pkg::MARK_SECOND) begin
          open_string(pos - 1);
        end else begin
          prev_byte = w.data_byte;
          prev_ok   = 1'b1;
        end
      end
    endcase
    byte_pos = pos + 1;
    // end of image flushes, then everything but the registers resets
    if (w.end_of_data) begin
      if (scan_ph != HUNT && n == 0) emit_string(n);
      clear_scan();
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // send one word; valid stays up after acceptance until the next call
  task automatic send_word(ubss_pkg::in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= w;
    do @(posedge clk); while (!in_ready);
    scan_byte(w);
  endtask

  task automatic push_byte(logic [7:0] b, bit eod = 1'b0);
    ubss_pkg::in_word_t w;
    w.data_byte   = b;
    w.end_of_data = eod;
    image_q       = {image_q, w};
  endtask

  task automatic push_unit(logic [15:0] u);
    push_byte(u[7:0]);
    push_byte(u[15:8]);
  endtask

  task automatic push_marker();
    push_byte(ubss_pkg::MARK_FIRST);
    push_byte(ubss_pkg::MARK_SECOND);
  endtask

  task automatic push_string(string s);
    for (int i = 0; i < s.len(); i++) push_unit({8'h00, s[i]});
  endtask

  task automatic push_random_chars(int n);
    repeat (n) push_unit({8'h00, 8'($urandom_range(32, 126))});
  endtask

  task automatic send_image();
    foreach (image_q[i]) send_word(image_q[i]);
    image_q.delete();
  endtask

  // drop valid and wait for the output side to drain
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_chars.size() != 0 && waited < 1000000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_chars.size() != 0) begin
      note_error($sformatf("%0d characters never arrived", expected_chars.size()));
      expected_chars.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [ubss_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ubss_pkg::REG_PREFIX_MODE) prefix_q = val[0];
    else min_len_q = val;
    @(posedge clk);
  endtask

  task automatic configure(bit pm, logic [ubss_pkg::CFG_W-1:0] ml);
    settle();
    write_reg(ubss_pkg::REG_PREFIX_MODE, {{(ubss_pkg::CFG_W-1){1'b0}}, pm});
    write_reg(ubss_pkg::REG_MIN_LENGTH, ml);
  endtask

  // strict: marker unit, spoiled string, lone low byte at end of data
  task automatic test_strict_directed();
    idle_on = 1'b0;
    configure(1'b0, 7'd0);
    push_marker();
    push_string("A~");
    push_marker();
    push_string(" ");
    push_unit(16'h007F);
    push_unit(ubss_pkg::UNIT_NUL);
    push_marker();
    push_string("A");
    push_byte(8'h51, 1'b1);
    send_image();
    settle();
  endtask

  // prefix: bad unit ends string and its high byte starts the next marker
  task automatic test_prefix_directed();
    idle_on = 1'b1;
    configure(1'b1, 7'd1);
    push_marker();
    push_string("OK");
    push_unit(16'hFF00);
    push_byte(ubss_pkg::MARK_SECOND);
    push_string("B");
    push_unit(ubss_pkg::UNIT_NUL);
    push_byte(ubss_pkg::MARK_SECOND, 1'b1);
    send_image();
    settle();
  endtask

  // string spoiled under strict, then finished under prefix
  task automatic test_mode_switch();
    configure(1'b0, 7'd0);
    push_marker();
    push_string("a");
    push_unit(16'h0001);
    send_image();
    configure(1'b1, 7'd0);
    push_string("b");
    push_unit(ubss_pkg::UNIT_NUL);
    push_byte(8'h00, 1'b1);
    send_image();
    settle();
  endtask

  // one character past a full buffer drops the string; a minimum above
  // the buffer size keeps nothing
  task automatic test_buffer_limit();
    idle_on = 1'b1;
    configure(1'b0, 7'd0);
    push_marker();
    push_random_chars(MAX_LEN + 1);
    push_byte(8'h00, 1'b1);
    send_image();
    configure(1'b1, 7'd65);
    push_marker();
    push_string("abc");
    push_byte(8'hFF, 1'b1);
    send_image();
    settle();
  endtask

  task automatic push_bad_unit();
    case ($urandom_range(0, 2))
      0: push_unit({8'h00, 8'($urandom_range(0, 31))});
      1: push_unit(16'h007F);
      default: push_unit({8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))});
    endcase
  endtask

  // mostly well-formed strings, some noise and broken markers
  task automatic add_segment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      push_marker();
      push_random_chars($urandom_range(0, 8));
      case ($urandom_range(0, 3))
        0: push_unit(ubss_pkg::UNIT_NUL);
        1: push_marker();
        2: push_bad_unit();
        default: ;
      endcase
    end else if (r < 85) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(ubss_pkg::MARK_FIRST);
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic(bit pm, logic [ubss_pkg::CFG_W-1:0] ml, bit idle,
                                     int n_bytes);
    idle_on = idle;
    configure(pm, ml);
    while (image_q.size() < n_bytes) add_segment();
    foreach (image_q[i]) if ($urandom_range(0, 99) < 3) image_q[i].end_of_data = 1'b1;
    // sometimes leave the image open across a register change
    if ($urandom_range(0, 99) < 85) image_q[image_q.size()-1].end_of_data = 1'b1;
    send_image();
    settle();
  endtask

  // output stalls: mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 30) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(8, 30);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each accepted word with the oldest expected character
  always @(posedge clk) begin
    ubss_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        note_error($sformatf("unexpected word: offset %h char %h last %b",
                             out_payload.string_offset, out_payload.character,
                             out_payload.last_of_string));
      end else begin
        want = expected_chars.pop_front();
        if (out_payload.string_offset !== want.string_offset ||
            out_payload.character !== want.character ||
            out_payload.last_of_string !== want.last_of_string)
          note_error($sformatf("mismatch: offset %h/%h char %h/%h last %b/%b (exp/act)",
                               want.string_offset, out_payload.string_offset,
                               want.character, out_payload.character,
                               want.last_of_string, out_payload.last_of_string));
      end
    end
  end

  initial begin
    prefix_q  = 1'b0;
    min_len_q = '0;
    clear_scan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_strict_directed();
    test_prefix_directed();
    test_mode_switch();
    test_buffer_limit();
    test_random_traffic(1'b0, 7'($urandom_range(0, 127)), 1'b1, 15);
    test_random_traffic(1'b1, 7'd0, 1'b0, 15);
    test_random_traffic(1'b1, 7'($urandom_range(1, 6)), 1'b1, 15);
    settle();
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
